@@ hw/rtl/sma_pkg.sv @@
// Shared constants, payload types, state and command types for the moving average block.
package sma_pkg;

    // Ring depth; must be a power of two so the pointer wraps naturally.
    localparam int WINDOW_MAX = 256;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int PRICE_W    = 32;
    localparam int WIN_W      = 9;
    localparam int SUM_W      = PRICE_W + PTR_W;
    localparam int CNT_W      = $clog2(SUM_W);

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(20);

    typedef struct packed {
        logic [PRICE_W-1:0] close_price;
        logic               series_start;
    } t_in;

    typedef struct packed {
        logic [PRICE_W-1:0] average;
        logic               valid_res;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic read;
        logic update;
        logic div_load;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic win_zero;
        logic full_next;
    } t_stat;

endpackage

@@ hw/rtl/sma_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sma_dp.sv @@
// Datapath: window register, sample ring, running sum, serial divider and result register.
module sma_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sma_pkg::WIN_W-1:0]   i_cfg_data,
    input  sma_pkg::t_in                i_in,
    input  sma_pkg::t_cmd               i_cmd,
    output sma_pkg::t_stat              o_stat,
    output sma_pkg::t_out               o_out
);

    logic [sma_pkg::WIN_W-1:0]   r_win, n_win;
    logic [sma_pkg::PTR_W-1:0]   r_wp, n_wp;
    logic [sma_pkg::WIN_W-1:0]   r_seen, n_seen;
    logic [sma_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [sma_pkg::PRICE_W-1:0] r_price, n_price;
    logic                        r_full, n_full;
    logic [sma_pkg::SUM_W-1:0]   r_quo, n_quo;
    logic [sma_pkg::WIN_W-1:0]   r_rem, n_rem;
    sma_pkg::t_out               r_out, n_out;

    logic [sma_pkg::WIN_W-1:0]   eff_win;
    logic [sma_pkg::PTR_W-1:0]   old_idx;
    logic [sma_pkg::PRICE_W-1:0] ram_rdata;
    logic                        seen_full;
    logic [sma_pkg::WIN_W-1:0]   seen_inc;
    logic [sma_pkg::WIN_W:0]     trial;
    logic                        ge;

    assign eff_win   = (32'(r_win) > 32'(sma_pkg::WINDOW_MAX))
                       ? sma_pkg::WIN_W'(sma_pkg::WINDOW_MAX) : r_win;
    assign old_idx   = r_wp - sma_pkg::PTR_W'(eff_win);
    assign seen_full = r_seen >= eff_win;
    assign seen_inc  = seen_full ? r_seen : sma_pkg::WIN_W'(r_seen + 1'b1);
    assign trial     = {r_rem, r_quo[sma_pkg::SUM_W-1]};
    assign ge        = trial >= {1'b0, eff_win};

    assign o_stat.win_zero  = (r_win == '0);
    assign o_stat.full_next = seen_inc >= eff_win;
    assign o_out            = r_out;

    sma_ram #(
        .WIDTH (sma_pkg::PRICE_W),
        .DEPTH (sma_pkg::WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_wp),
        .i_wdata (r_price),
        .i_re    (i_cmd.read),
        .i_raddr (old_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_win   = r_win;
        n_wp    = r_wp;
        n_seen  = r_seen;
        n_sum   = r_sum;
        n_price = r_price;
        n_full  = r_full;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_out   = r_out;
        if (i_cfg_we) begin
            n_win  = i_cfg_data;
            n_wp   = '0;
            n_seen = '0;
            n_sum  = '0;
        end
        if (i_cmd.accept) begin
            n_price = i_in.close_price;
            n_full  = 1'b0;
            if (i_in.series_start) begin
                n_wp   = '0;
                n_seen = '0;
                n_sum  = '0;
            end
        end
        if (i_cmd.read) begin
            n_sum = r_sum + sma_pkg::SUM_W'(r_price);
        end
        if (i_cmd.update) begin
            n_sum  = seen_full ? r_sum - sma_pkg::SUM_W'(ram_rdata) : r_sum;
            n_wp   = sma_pkg::PTR_W'(r_wp + 1'b1);
            n_seen = seen_inc;
            n_full = o_stat.full_next;
        end
        if (i_cmd.div_load) begin
            n_quo = n_sum;
            n_rem = '0;
        end
        if (i_cmd.div_step) begin
            n_rem = ge ? sma_pkg::WIN_W'(trial - {1'b0, eff_win}) : trial[sma_pkg::WIN_W-1:0];
            n_quo = {r_quo[sma_pkg::SUM_W-2:0], ge};
        end
        if (i_cmd.load_out) begin
            n_out.average   = r_full ? r_quo[sma_pkg::PRICE_W-1:0] : '0;
            n_out.valid_res = r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= sma_pkg::WIN_RESET;
            r_wp   <= '0;
            r_seen <= '0;
            r_sum  <= '0;
            r_full <= 1'b0;
        end else begin
            r_win  <= n_win;
            r_wp   <= n_wp;
            r_seen <= n_seen;
            r_sum  <= n_sum;
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_price <= n_price;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_out   <= n_out;
    end

endmodule

@@ hw/rtl/sma_ctrl.sv @@
// Controller: sequences ring read, sum update, serial division and result hand-off.
module sma_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_cfg_ready,
    input  sma_pkg::t_stat i_stat,
    output sma_pkg::t_cmd  o_cmd
);

    sma_pkg::t_state         r_state, n_state;
    logic [sma_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == sma_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == sma_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sma_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            sma_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.win_zero ? sma_pkg::S_FINISH : sma_pkg::S_READ;
                end
            end
            sma_pkg::S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = sma_pkg::S_UPDATE;
            end
            sma_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                if (i_stat.full_next) begin
                    o_cmd.div_load = 1'b1;
                    n_cnt          = '0;
                    n_state        = sma_pkg::S_DIV;
                end else begin
                    n_state = sma_pkg::S_FINISH;
                end
            end
            sma_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == sma_pkg::CNT_W'(sma_pkg::SUM_W - 1)) begin
                    n_cnt   = '0;
                    n_state = sma_pkg::S_FINISH;
                end else begin
                    n_cnt = sma_pkg::CNT_W'(r_cnt + 1'b1);
                end
            end
            sma_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = sma_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sma_pkg::S_IDLE;
            end
        endcase
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while held");

    a_update_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |-> $past(o_cmd.read))
        else $error("sum update without a preceding ring read");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sma_pkg::S_DIV) |-> (r_cnt < sma_pkg::CNT_W'(sma_pkg::SUM_W)))
        else $error("divider step count out of range");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == sma_pkg::S_READ || r_state == sma_pkg::S_FINISH))
        else $error("accepted transaction not started");

endmodule

@@ hw/rtl/simple_moving_average.sv @@
// Top level of the simple moving average block.
// Input channel (i_valid/o_ready, i_data): one price sample per transaction,
// unsigned Q16.16, with series_start to clear the history before the sample.
// Output channel (o_valid/i_ready, o_data): one result per sample; average is
// the mean of the last window_size samples (at most 256), truncated, once a
// full window has been seen, otherwise 0 with valid_res clear.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_data): writes window_size,
// taken only while idle; a write also clears the current series.
// Sequence: with a full window a sample passes through ring read, sum update,
// 40 restoring divide steps on the 40-bit sum and result load; while the
// window is not yet full the divide steps are skipped, and with window_size
// zero only the result load follows the input transaction.
// A new sample is taken only after the previous one has left its last step,
// so the serial divider bounds the sample rate with a full window.
// Reset: window_size returns to 20, the series is cleared; ring contents are
// not cleared and need no clearing pass.
// Stall: a result waits in the output register; the next sample is taken and
// processed, then holds in its last step until the register is free.
module simple_moving_average (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  sma_pkg::t_in              i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output sma_pkg::t_out             o_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [sma_pkg::WIN_W-1:0] i_cfg_data
);

    sma_pkg::t_cmd  cmd;
    sma_pkg::t_stat stat;
    logic           cfg_we;

    assign cfg_we = i_cfg_valid && o_cfg_ready;

    sma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sma_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out      (o_data)
    );

endmodule
